FILE: src/cbs_pkg.sv
// ----------------------------------------------------------------------------
// cbs_pkg
// shared types and widths for the cubic bezier sampler
// ----------------------------------------------------------------------------
`default_nettype none

package cbs_pkg;

    localparam int COORD_W = 16;
    localparam int STEP_W  = 6;
    localparam int WGT_W   = 17;
    localparam int PROD_W  = 33;
    localparam int SUM_W   = 35;
    localparam int NUM_PTS = 8;
    localparam int NUM_TRM = 4;
    localparam int STEPS   = 64;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [WGT_W-1:0]   weight_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic        [STEP_W-1:0]  step_t;

    // control that travels with one sample through the pipeline
    typedef struct packed {
        logic  valid;
        step_t index;
        logic  last;
    } meta_t;

endpackage

`default_nettype wire

FILE: src/cbs_lane.sv
// ----------------------------------------------------------------------------
// cbs_lane
// one bernstein term: weight times coordinate, registered
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_lane (
    input  wire             aclk,
    input  wire             adv,
    input  cbs_pkg::weight_t weight,
    input  cbs_pkg::coord_t  coord,
    output cbs_pkg::prod_t   prod_reg
);
    import cbs_pkg::*;

    logic signed [WGT_W:0]            w_s;
    logic signed [WGT_W+COORD_W:0]    full;
    prod_t                            prod_next;

    // weight is unsigned, widen by one zero bit before the signed multiply
    assign w_s       = signed'({1'b0, weight});
    assign full      = w_s * coord;
    assign prod_next = full[PROD_W-1:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= prod_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/cbs_merge.sv
// ----------------------------------------------------------------------------
// cbs_merge
// sums the lane products per axis, rounds, saturates and drives the output beat
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_merge (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  cbs_pkg::prod_t                prods [cbs_pkg::NUM_PTS],
    input  cbs_pkg::meta_t                meta,
    output logic                          adv,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // m_tdata fields from bit 0: curve_x[15:0], curve_y[15:0], sample_number[5:0], zero pad
    output logic [39:0]                   m_tdata,
    output logic                          m_tlast
);
    import cbs_pkg::*;

    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;
    coord_t                    x_next;
    coord_t                    y_next;
    coord_t                    x_reg;
    coord_t                    y_reg;
    step_t                     idx_reg;
    logic                      last_reg;
    logic                      valid_reg;

    // round half up, dropping the q.16 weight fraction, and clamp to the 16 bit range
    function automatic coord_t round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] b;
        logic signed [SUM_W-17:0] r;
        b = s + SUM_W'(32768);
        r = b[SUM_W-1:16];
        if (r > (SUM_W-16)'(32767)) begin
            round_sat = 16'sh7fff;
        end else if (r < -(SUM_W-16)'(32768)) begin
            round_sat = 16'sh8000;
        end else begin
            round_sat = r[COORD_W-1:0];
        end
    endfunction

    // even lanes carry x terms, odd lanes y terms
    always_comb begin
        sum_x = '0;
        sum_y = '0;
        for (int k = 0; k < NUM_TRM; k++) begin
            sum_x = sum_x + SUM_W'(prods[2*k]);
            sum_y = sum_y + SUM_W'(prods[2*k+1]);
        end
        x_next = round_sat(sum_x);
        y_next = round_sat(sum_y);
    end

    // pipeline moves whenever the output register is free or being taken
    assign adv = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= meta.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            idx_reg  <= meta.index;
            last_reg <= meta.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, idx_reg, y_reg, x_reg};
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: src/cbs_seq.sv
// ----------------------------------------------------------------------------
// cbs_seq
// holds the control points and steps through the samples, one per cycle while adv is high
// ----------------------------------------------------------------------------
`default_nettype none

module cbs_seq #(
    parameter int SEGMENTS = 30
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  cbs_pkg::coord_t     s_points [cbs_pkg::NUM_PTS],
    input  wire                 adv,
    output cbs_pkg::coord_t     points [cbs_pkg::NUM_PTS],
    output cbs_pkg::weight_t    weights [cbs_pkg::NUM_TRM],
    output cbs_pkg::meta_t      meta
);
    import cbs_pkg::*;

    localparam int     SEG  = (SEGMENTS < 1) ? 1 : ((SEGMENTS > 63) ? 63 : SEGMENTS);
    localparam longint DEN  = longint'(SEG) * SEG * SEG;
    localparam step_t  LAST = STEP_W'(SEG);

    weight_t w_tab [STEPS][NUM_TRM];
    coord_t  pts_reg [NUM_PTS];
    step_t   step_reg;
    step_t   step_next;
    logic    busy_reg;
    logic    busy_next;
    logic    at_last;
    logic    accept;

    // bernstein weight table, rounded to q1.16 at elaboration
    for (genvar gi = 0; gi < STEPS; gi++) begin : g_wtab
        if (gi <= SEG) begin : g_used
            localparam longint J  = SEG - gi;
            localparam longint I  = gi;
            localparam longint W0 = (J * J * J * 65536 + DEN / 2) / DEN;
            localparam longint W1 = (3 * I * J * J * 65536 + DEN / 2) / DEN;
            localparam longint W2 = (3 * I * I * J * 65536 + DEN / 2) / DEN;
            localparam longint W3 = (I * I * I * 65536 + DEN / 2) / DEN;
            assign w_tab[gi][0] = WGT_W'(W0);
            assign w_tab[gi][1] = WGT_W'(W1);
            assign w_tab[gi][2] = WGT_W'(W2);
            assign w_tab[gi][3] = WGT_W'(W3);
        end else begin : g_unused
            for (genvar gk = 0; gk < NUM_TRM; gk++) begin : g_zero
                assign w_tab[gi][gk] = '0;
            end
        end
    end

    // a new curve is taken when idle or as the last sample issues
    assign at_last  = (step_reg == LAST);
    assign s_tready = !busy_reg || (adv && at_last);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (accept) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (busy_reg && adv) begin
            if (at_last) begin
                busy_next = 1'b0;
                step_next = '0;
            end else begin
                step_next = step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pts_reg <= s_points;
        end
    end

    // issue the current sample to the lanes
    assign points     = pts_reg;
    assign weights    = w_tab[step_reg];
    assign meta.valid = busy_reg;
    assign meta.index = step_reg;
    assign meta.last  = at_last;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> busy_reg && step_reg == '0)
        else $error("accepted curve did not restart the step counter");
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> step_reg <= LAST)
        else $error("step counter ran past the last sample");
    a_ready_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && busy_reg) |-> (at_last && adv))
        else $error("ready raised while a curve is still mid-way");
`endif

endmodule

`default_nettype wire

FILE: src/cubic_bezier_sampler_top.sv
// first sample of a curve: the input beat passes the sequencer, lane and output registers in that order
// one sample per cycle from the step counter while the output is not stalled
// a new curve is taken as the previous curve issues its last sample
// output stalls hold the whole pipeline, the input waits with it
// reset: synchronous active low aresetn clears the step counter and valid flags
// ----------------------------------------------------------------------------
// cubic_bezier_sampler_top
// samples a cubic bezier curve at SEGMENTS+1 evenly spaced points
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_sampler_top #(
    parameter int SEGMENTS = 30
) (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    // s_tdata fields from bit 0: p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y (16 bit each)
    input  wire  [127:0] s_tdata,
    output logic         m_tvalid,
    input  wire          m_tready,
    // m_tdata fields from bit 0: curve_x[15:0], curve_y[15:0], sample_number[5:0], zero pad
    output logic [39:0]  m_tdata,
    output logic         m_tlast
);
    import cbs_pkg::*;

    coord_t  s_points [NUM_PTS];
    coord_t  points   [NUM_PTS];
    weight_t weights  [NUM_TRM];
    prod_t   prods    [NUM_PTS];
    meta_t   meta;
    meta_t   meta1_reg;
    logic    adv;

    // unpack the input beat
    for (genvar gp = 0; gp < NUM_PTS; gp++) begin : g_unpack
        assign s_points[gp] = s_tdata[gp*COORD_W +: COORD_W];
    end

    cbs_seq #(
        .SEGMENTS (SEGMENTS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_points (s_points),
        .adv      (adv),
        .points   (points),
        .weights  (weights),
        .meta     (meta)
    );

    // one lane per control point coordinate, weight picked by term
    for (genvar gl = 0; gl < NUM_PTS; gl++) begin : g_lane
        cbs_lane u_lane (
            .aclk     (aclk),
            .adv      (adv),
            .weight   (weights[gl/2]),
            .coord    (points[gl]),
            .prod_reg (prods[gl])
        );
    end

    // sample control alongside the lane products
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            meta1_reg <= '0;
        end else if (adv) begin
            meta1_reg <= meta;
        end
    end

    cbs_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .prods    (prods),
        .meta     (meta1_reg),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire
